@@ rtl/phsop_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// phsop_pkg
// Shared constants and tables of the phase-shift operator generator.
// ----------------------------------------------------------------------------
package phsop_pkg;

  localparam int WAVENUMBER_BITS_DEF = 16;

  // configuration port
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 16;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEPTH_STEP    = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BACKWARD_MODE = 4'd1;
  localparam logic [15:0] DEPTH_STEP_RESET = 16'd256;

  // angles in Q.18 radians
  localparam int PH_W = 21;
  localparam logic [PH_W-1:0] TWO_PI_Q18        = 21'd1647099;
  localparam logic [PH_W-1:0] PI_Q18            = 21'd823550;
  localparam logic [PH_W-1:0] HALF_PI_Q18       = 21'd411775;
  localparam logic [PH_W-1:0] THREE_HALF_PI_Q18 = 21'd1235324;

  // CORDIC datapath
  localparam int CORDIC_STEPS = 16;
  localparam int XW = 28;
  localparam int ZW = 23;
  localparam logic signed [XW-1:0] CORDIC_X0_Q24 = 28'sd10188014;

  // decay series
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam int DECAY_LIMIT_Q18 = 16 << 18;
  localparam logic [21:0] RECIP6 = 22'd2796203;  // ceil(2^24 / 6)
  localparam logic [18:0] RECIP3 = 19'd349526;   // ceil(2^20 / 3)

  localparam int OUT_MAX = 16384;

  function automatic logic signed [ZW-1:0] atan_q18(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0: v = 23'sd205887;
      1: v = 23'sd121542;
      2: v = 23'sd64220;
      3: v = 23'sd32599;
      4: v = 23'sd16363;
      5: v = 23'sd8189;
      6: v = 23'sd4096;
      7: v = 23'sd2048;
      8: v = 23'sd1024;
      9: v = 23'sd512;
      10: v = 23'sd256;
      11: v = 23'sd128;
      12: v = 23'sd64;
      13: v = 23'sd32;
      14: v = 23'sd16;
      15: v = 23'sd8;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/phase_shift_operator_generator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// phase_shift_operator_generator_top
// Pipelined generator of complex phase-shift extrapolation operator entries.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): one request per (k, kx) pair, with a
//    last_pair flag that is passed through to last_out.
//  - Output channel (out_valid/out_ready): one result per request, in order:
//    op_real/op_imag in signed Q1.14 and the evanescent flag.
//  - Config channel (cfg_valid/cfg_ready): index 0 depth step (Q8.8),
//    index 1 backward mode. Always ready; write only while the pipe is empty.
//  - Stages: squares, one square-root bit per stage, the dz products, one
//    2*pi subtract per stage, 16 CORDIC stages with the exp() series and
//    squarings alongside, then the scale multiply and the round/clamp stage.
//  - Throughput is one request per cycle while out_ready stays high.
//  - Each stage holds its own valid bit; a stage loads when it is empty or
//    its successor moves, so a stalled receiver fills bubbles first and
//    in_ready only drops once every stage holds a request.
//  - Reset clears all valid bits and restores dz = 1.0, forward mode.
// ----------------------------------------------------------------------------
module phase_shift_operator_generator_top #(
  parameter int WAVENUMBER_BITS = phsop_pkg::WAVENUMBER_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [WAVENUMBER_BITS-1:0]             wavenumber,
  input  wire logic [WAVENUMBER_BITS-1:0]             lateral_wavenumber,
  input  wire logic                                   last_pair,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [15:0]                          op_real,
  output logic signed [15:0]                          op_imag,
  output logic                                        evanescent,
  output logic                                        last_out,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [phsop_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [phsop_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import phsop_pkg::*;

  localparam int W    = WAVENUMBER_BITS;
  localparam int W2   = 2 * W;
  localparam int MAGW = W + 16;
  localparam int MODJ = MAGW - PH_W;     // top shift of the 2*pi subtract
  localparam int PW   = 60;
  // stage map
  localparam int B1  = 3 + W;            // dz products
  localparam int B2  = B1 + 1;           // first modulo stage
  localparam int B3  = B2 + MODJ + 1;    // fold / CORDIC load
  localparam int B4  = B3 + 1;           // first CORDIC stage
  localparam int B5  = B4 + CORDIC_STEPS;// scale multiply
  localparam int B6  = B5 + 1;           // round and clamp
  localparam int NST = B6 + 1;

  typedef struct packed {
    logic [W-1:0]          k;
    logic [W-1:0]          kx;
    logic                  last;
    logic                  evan;
    logic [W2-1:0]         sqk;
    logic [W2-1:0]         sqkx;
    logic [W2-1:0]         rem;
    logic [W2-1:0]         res;
    logic [MAGW-1:0]       mag;
    logic [MAGW-1:0]       dd;
    logic                  sat;
    logic                  neg;
    logic signed [XW-1:0]  x;
    logic signed [XW-1:0]  y;
    logic signed [ZW-1:0]  z;
    logic [25:0]           a;
    logic [21:0]           t2;
    logic [17:0]           t3;
    logic [13:0]           t4;
    logic [17:0]           q6;
    logic [10:0]           q24;
    logic [30:0]           p;
    logic signed [PW-1:0]  pr;
    logic signed [PW-1:0]  pim;
    logic signed [15:0]    ore;
    logic signed [15:0]    oim;
  } item_t;

  logic [15:0] depth_step;
  logic        backward_mode;

  item_t       pipe [NST];
  item_t       nxt  [NST];
  logic [NST-1:0] vld;
  logic [NST:0]   en;

  // config registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_step    <= DEPTH_STEP_RESET;
      backward_mode <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEPTH_STEP:    depth_step    <= cfg_data;
        CFG_BACKWARD_MODE: backward_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ready ripples back through empty stages
  always_comb begin
    en[NST] = out_ready;
    for (int s = NST - 1; s >= 0; s--) begin
      en[s] = ~vld[s] | en[s+1];
    end
  end
  assign in_ready = en[0];

  // stage 0: capture
  always_comb begin
    nxt[0]      = '0;
    nxt[0].k    = wavenumber;
    nxt[0].kx   = lateral_wavenumber;
    nxt[0].last = last_pair;
  end

  // stage 1: squares
  always_comb begin
    nxt[1]      = pipe[0];
    nxt[1].sqk  = W2'(pipe[0].k) * W2'(pipe[0].k);
    nxt[1].sqkx = W2'(pipe[0].kx) * W2'(pipe[0].kx);
  end

  // stage 2: branch and difference
  always_comb begin
    nxt[2]      = pipe[1];
    nxt[2].evan = pipe[1].kx > pipe[1].k;
    nxt[2].rem  = (pipe[1].kx > pipe[1].k) ? (pipe[1].sqkx - pipe[1].sqk)
                                           : (pipe[1].sqk - pipe[1].sqkx);
    nxt[2].res  = '0;
  end

  // square root, one result bit per stage
  for (genvar j = 0; j < W; j++) begin : g_sqrt
    localparam logic [W2-1:0] BIT = W2'(1) << (W2 - 2 - 2 * j);
    always_comb begin
      nxt[3+j] = pipe[2+j];
      if (pipe[2+j].rem >= pipe[2+j].res + BIT) begin
        nxt[3+j].rem = pipe[2+j].rem - (pipe[2+j].res + BIT);
        nxt[3+j].res = (pipe[2+j].res >> 1) + BIT;
      end else begin
        nxt[3+j].res = pipe[2+j].res >> 1;
      end
    end
  end

  // phase magnitude and decay exponent
  always_comb begin
    nxt[B1] = pipe[B1-1];
    if (pipe[B1-1].evan) begin
      nxt[B1].mag = MAGW'(pipe[B1-1].k) * MAGW'(depth_step);
    end else begin
      nxt[B1].mag = MAGW'(pipe[B1-1].k - pipe[B1-1].res[W-1:0]) * MAGW'(depth_step);
    end
    nxt[B1].dd  = MAGW'(pipe[B1-1].res[W-1:0]) * MAGW'(depth_step);
    nxt[B1].sat = (MAGW'(pipe[B1-1].res[W-1:0]) * MAGW'(depth_step))
                  >= MAGW'(DECAY_LIMIT_Q18);
  end

  // modulo 2*pi by shifted subtracts
  for (genvar m = 0; m <= MODJ; m++) begin : g_mod
    localparam logic [MAGW-1:0] CM = MAGW'(TWO_PI_Q18) << (MODJ - m);
    always_comb begin
      nxt[B2+m] = pipe[B2+m-1];
      if (pipe[B2+m-1].mag >= CM) begin
        nxt[B2+m].mag = pipe[B2+m-1].mag - CM;
      end
    end
  end

  // direction, quadrant fold, CORDIC load
  logic [PH_W-1:0] ang;
  always_comb begin
    nxt[B3] = pipe[B3-1];
    ang = pipe[B3-1].mag[PH_W-1:0];
    if (backward_mode && ang != '0) begin
      ang = TWO_PI_Q18 - ang;
    end
    nxt[B3].neg = 1'b0;
    if (ang <= HALF_PI_Q18) begin
      nxt[B3].z = ZW'(ang);
    end else if (ang <= THREE_HALF_PI_Q18) begin
      nxt[B3].z   = ZW'(ang) - ZW'(PI_Q18);
      nxt[B3].neg = 1'b1;
    end else begin
      nxt[B3].z = ZW'(ang) - ZW'(TWO_PI_Q18);
    end
    nxt[B3].x = CORDIC_X0_Q24;
    nxt[B3].y = '0;
    nxt[B3].a = {pipe[B3-1].dd[21:0], 4'b0000};
  end

  // CORDIC rotations; the exp(-D) series runs in the same stages
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    always_comb begin
      nxt[B4+i] = pipe[B3+i];
      if (!pipe[B3+i].z[ZW-1]) begin
        nxt[B4+i].x = pipe[B3+i].x - (pipe[B3+i].y >>> i);
        nxt[B4+i].y = pipe[B3+i].y + (pipe[B3+i].x >>> i);
        nxt[B4+i].z = pipe[B3+i].z - atan_q18(i);
      end else begin
        nxt[B4+i].x = pipe[B3+i].x + (pipe[B3+i].y >>> i);
        nxt[B4+i].y = pipe[B3+i].y - (pipe[B3+i].x >>> i);
        nxt[B4+i].z = pipe[B3+i].z + atan_q18(i);
      end
      if (i == 0) begin
        nxt[B4+i].t2 = 22'((52'(pipe[B3+i].a) * 52'(pipe[B3+i].a)) >> 30);
      end else if (i == 1) begin
        nxt[B4+i].t3 = 18'((48'(pipe[B3+i].t2) * 48'(pipe[B3+i].a)) >> 30);
      end else if (i == 2) begin
        nxt[B4+i].t4 = 14'((44'(pipe[B3+i].t3) * 44'(pipe[B3+i].a)) >> 30);
        nxt[B4+i].q6 = 18'((40'(pipe[B3+i].t3) * 40'(RECIP6)) >> 24);
      end else if (i == 3) begin
        nxt[B4+i].q24 = 11'((32'(pipe[B3+i].t4 >> 3) * 32'(RECIP3)) >> 20);
      end else if (i == 4) begin
        nxt[B4+i].p = pipe[B3+i].sat ? '0 :
          31'(32'(ONE_Q30) - 32'(pipe[B3+i].a) + 32'(pipe[B3+i].t2 >> 1)
              - 32'(pipe[B3+i].q6) + 32'(pipe[B3+i].q24));
      end else if (i <= 12) begin
        nxt[B4+i].p = 31'((62'(pipe[B3+i].p) * 62'(pipe[B3+i].p)
                           + (62'(1) << 29)) >> 30);
      end
    end
  end

  // half-plane restore and scale
  logic signed [XW-1:0] xs, ys;
  logic signed [31:0]   pe;
  always_comb begin
    nxt[B5] = pipe[B5-1];
    xs = pipe[B5-1].neg ? -pipe[B5-1].x : pipe[B5-1].x;
    ys = pipe[B5-1].neg ? -pipe[B5-1].y : pipe[B5-1].y;
    pe = pipe[B5-1].evan ? $signed({1'b0, pipe[B5-1].p}) : $signed({1'b0, ONE_Q30});
    nxt[B5].pr  = PW'(xs) * PW'(pe);
    nxt[B5].pim = PW'(ys) * PW'(pe);
  end

  // round and clamp
  logic signed [PW-1:0] rr, ri;
  logic signed [19:0]   sr, si;
  always_comb begin
    nxt[B6] = pipe[B6-1];
    rr = (pipe[B6-1].pr + (PW'(1) <<< 39)) >>> 40;
    ri = (pipe[B6-1].pim + (PW'(1) <<< 39)) >>> 40;
    sr = rr[19:0];
    si = ri[19:0];
    if (sr > 20'sd16384)       nxt[B6].ore = 16'sd16384;
    else if (sr < -20'sd16384) nxt[B6].ore = -16'sd16384;
    else                       nxt[B6].ore = sr[15:0];
    if (si > 20'sd16384)       nxt[B6].oim = 16'sd16384;
    else if (si < -20'sd16384) nxt[B6].oim = -16'sd16384;
    else                       nxt[B6].oim = si[15:0];
  end

  // pipeline registers
  for (genvar s = 0; s < NST; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en[s]) begin
        vld[s] <= (s == 0) ? in_valid : vld[(s == 0) ? 0 : s - 1];
      end
    end
    always_ff @(posedge clk) begin
      if (en[s]) begin
        pipe[s] <= nxt[s];
      end
    end
  end

  assign out_valid  = vld[NST-1];
  assign op_real    = pipe[NST-1].ore;
  assign op_imag    = pipe[NST-1].oim;
  assign evanescent = pipe[NST-1].evan;
  assign last_out   = pipe[NST-1].last;

endmodule
`default_nettype wire

@@ rtl/phsop_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// phsop_checker
// Port-level checks of the phase-shift operator generator.
// ----------------------------------------------------------------------------
module phsop_checker #(
  parameter int WAVENUMBER_BITS = phsop_pkg::WAVENUMBER_BITS_DEF
) (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 in_valid,
  input wire logic                                 in_ready,
  input wire logic [WAVENUMBER_BITS-1:0]           wavenumber,
  input wire logic [WAVENUMBER_BITS-1:0]           lateral_wavenumber,
  input wire logic                                 last_pair,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic signed [15:0]                   op_real,
  input wire logic signed [15:0]                   op_imag,
  input wire logic                                 evanescent,
  input wire logic                                 last_out,
  input wire logic                                 cfg_valid,
  input wire logic                                 cfg_ready,
  input wire logic [phsop_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input wire logic [phsop_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  // empty output stage means the whole ready chain is open
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("in_ready low with empty output");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("result shown after reset");

  a_clamped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (op_real <= 16'sd16384 && op_real >= -16'sd16384 &&
                   op_imag <= 16'sd16384 && op_imag >= -16'sd16384))
    else $error("operator outside clamp range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(op_real) &&
      $stable(op_imag) && $stable(evanescent) && $stable(last_out))
    else $error("stalled result changed");

endmodule

bind phase_shift_operator_generator_top phsop_checker #(
  .WAVENUMBER_BITS(WAVENUMBER_BITS)
) u_phsop_checker (.*);
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the phase-shift operator generator: drives (k, kx)
// requests with random gaps and backpressure, recomputes every operator entry
// in fixed point and compares results in order, across several dz settings.
// ----------------------------------------------------------------------------
module tb;
  import phsop_pkg::*;

  localparam longint ATAN_TBL [16] = '{205887, 121542, 64220, 32599, 16363, 8189,
                                       4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8};

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    bit                 evan;
    bit                 last;
  } op_entry_t;

  // Operator scoreboard: holds dz/mode shadow and the pending entries.
  class op_scoreboard;
    op_entry_t pending[$];
    longint unsigned dz = DEPTH_STEP_RESET;
    bit backward = 0;
    int errors = 0;

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [15:0] val);
      if (idx == CFG_DEPTH_STEP) dz = val;
      else if (idx == CFG_BACKWARD_MODE) backward = val[0];
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function longint unsigned exp_neg(longint unsigned d);
      longint unsigned a, t2, t3, t4, p;
      if (d >= DECAY_LIMIT_Q18) return 0;
      a = d << 4;
      t2 = (a * a) >> 30;
      t3 = (t2 * a) >> 30;
      t4 = (t3 * a) >> 30;
      p = 64'd1073741824 - a + (t2 >> 1) - t3 / 6 + t4 / 24;
      for (int i = 0; i < 8; i++) p = (p * p + (64'd1 << 29)) >> 30;
      return p;
    endfunction

    function logic signed [15:0] scale_clamp(longint v, longint unsigned p);
      longint r;
      r = (v * longint'(p) + (longint'(1) << 39)) >>> 40;
      if (r > OUT_MAX) r = OUT_MAX;
      if (r < -OUT_MAX) r = -OUT_MAX;
      return r[15:0];
    endfunction

    // accepted request -> expected operator entry
    function void note_pair(logic [15:0] k_in, logic [15:0] kx_in, bit last);
      longint unsigned k, kx, mag, p, r, root;
      longint x, y, z, dx, dy;
      bit neg;
      op_entry_t e;
      k = k_in;
      kx = kx_in;
      e.evan = kx > k;
      if (!e.evan) begin
        root = int_sqrt(k * k - kx * kx);
        mag = (k - root) * dz;
        p = 64'd1073741824;
      end else begin
        root = int_sqrt(kx * kx - k * k);
        mag = k * dz;
        p = exp_neg(root * dz);
      end
      r = mag % TWO_PI_Q18;
      if (backward) r = (r == 0) ? 0 : (TWO_PI_Q18 - r);
      // fold into [-pi/2, pi/2] before the rotation
      neg = 0;
      if (r <= HALF_PI_Q18) z = r;
      else if (r <= THREE_HALF_PI_Q18) begin
        z = longint'(r) - PI_Q18;
        neg = 1;
      end else z = longint'(r) - TWO_PI_Q18;
      x = CORDIC_X0_Q24;
      y = 0;
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= ATAN_TBL[i];
        end else begin
          x += dx; y -= dy; z += ATAN_TBL[i];
        end
      end
      if (neg) begin
        x = -x; y = -y;
      end
      e.re = scale_clamp(x, p);
      e.im = scale_clamp(y, p);
      e.last = last;
      pending.push_back(e);
    endfunction

    task check_entry(logic signed [15:0] re, logic signed [15:0] im, bit evan, bit last);
      op_entry_t e;
      if (pending.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      e = pending.pop_front();
      if (re !== e.re) report($sformatf("op_real %0d exp %0d", re, e.re));
      if (im !== e.im) report($sformatf("op_imag %0d exp %0d", im, e.im));
      if (evan !== e.evan) report($sformatf("evanescent %0b exp %0b", evan, e.evan));
      if (last !== e.last) report($sformatf("last_out %0b exp %0b", last, e.last));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_ready;
  logic [15:0] wavenumber = 0, lateral_wavenumber = 0;
  logic last_pair = 0;
  logic out_valid, out_ready = 0;
  logic signed [15:0] op_real, op_imag;
  logic evanescent, last_out;
  logic cfg_valid = 0, cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = 0;
  logic [CFG_DATA_BITS-1:0] cfg_data = 0;

  op_scoreboard sb = new();
  int send_idle_pct = 0;  // percent of cycles the sender holds off
  int recv_idle_pct = 0;  // percent of cycles out_ready is low

  phase_shift_operator_generator_top u_top (
    .clk, .rst, .in_valid, .in_ready, .wavenumber, .lateral_wavenumber, .last_pair,
    .out_valid, .out_ready, .op_real, .op_imag, .evanescent, .last_out,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // receiver backpressure, changed on the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // output monitor: sample at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_entry(op_real, op_imag, evanescent, last_out);
  end

  // One request. Entered and left just after a falling edge.
  task send_pair(logic [15:0] k, logic [15:0] kx, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    wavenumber <= k;
    lateral_wavenumber <= kx;
    last_pair <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_pair(k, kx, last);
    @(negedge clk);
  endtask

  // let the pipe go empty, plus margin for the pipeline latency
  task drain;
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // one write, then cfg_valid goes low again before the task returns
  task write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task random_pairs(int n);
    logic [15:0] k, kx;
    for (int i = 0; i < n; i++) begin
      k = 16'($urandom);
      case ($urandom_range(3))
        0: kx = 16'($urandom);
        1: kx = (k > 16'hFFC0) ? k : 16'(k + $urandom_range(63));  // weak decay
        2: kx = 16'($urandom_range(k));                            // propagating
        default: kx = (k < 64) ? 16'($urandom_range(63)) : 16'(k - $urandom_range(63));
      endcase
      if ($urandom_range(1)) begin
        k = k >> $urandom_range(8);
        kx = kx >> $urandom_range(8);
      end
      send_pair(k, kx, 1'($urandom_range(1)));
      // once in the run: hold off until every pending result has come back
      if (i == n / 2 && send_idle_pct == 0) begin
        in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // phase 0: reset registers, directed corners
    send_idle_pct = 38;
    recv_idle_pct = 49;
    send_pair(16'd0, 16'd0, 1'b0);             // equal wavenumbers, zero
    send_pair(16'hFFFF, 16'hFFFF, 1'b1);       // equal wavenumbers, max
    send_pair(16'hFFFF, 16'd0, 1'b0);
    send_pair(16'd0, 16'hFFFF, 1'b1);          // strong decay
    send_pair(16'd1000, 16'd3000, 1'b0);
    send_pair(16'd1024, 16'd1030, 1'b1);       // light decay
    send_pair(16'd6434, 16'd0, 1'b0);          // no lateral wavenumber, zero phase
    send_pair(16'd3217, 16'd0, 1'b0);          // no lateral wavenumber, zero phase
    send_pair(16'd1608, 16'd1, 1'b1);          // near-zero phase
    send_pair(16'h5555, 16'hAAAA, 1'b0);
    send_pair(16'hAAAA, 16'h5555, 1'b1);
    send_pair(16'd1, 16'd2, 1'b0);
    random_pairs(110);
    drain;

    // phase 1: smallest nonzero dz, backward; stray index is ignored
    write_reg(CFG_DEPTH_STEP, 16'd1);
    write_reg(CFG_BACKWARD_MODE, 16'hFFFF);
    write_reg(4'd15, 16'h1234);
    send_pair(16'd0, 16'hFFFF, 1'b1);
    send_pair(16'hFFFF, 16'd0, 1'b0);
    random_pairs(120);
    drain;

    // phase 2: largest dz, forward
    send_idle_pct = 49;
    recv_idle_pct = 38;
    write_reg(CFG_DEPTH_STEP, 16'hFFFF);
    write_reg(CFG_BACKWARD_MODE, 16'hFFFE);
    send_pair(16'hFFFF, 16'hFFFF, 1'b0);
    send_pair(16'd5, 16'd6, 1'b1);
    random_pairs(120);
    drain;

    // phase 3: zero dz, backward
    write_reg(CFG_DEPTH_STEP, 16'd0);
    write_reg(CFG_BACKWARD_MODE, 16'd1);
    send_pair(16'd0, 16'hFFFF, 1'b0);
    send_pair(16'hFFFF, 16'd0, 1'b1);
    random_pairs(60);
    drain;

    // phase 4: random dz, no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_DEPTH_STEP, 16'($urandom_range(1, 65535)));
    write_reg(CFG_BACKWARD_MODE, 16'($urandom));
    random_pairs(220);
    drain;
    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/phsop_pkg.sv
rtl/phase_shift_operator_generator_top.sv
rtl/phsop_checker.sv
dv/tb.sv
